[rtl/core/otis_pkg.sv]
// ----------------------------------------------------------------------------
// otis_pkg
// Shared types and constants for the ordered table interpolation search unit:
// transfer payloads, status codes and the controller/datapath command links.
// ----------------------------------------------------------------------------
package otis_pkg;

  localparam int POS_W = 5;
  localparam int VAL_W = 32;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // input transfer payload
  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_item_t;

  // output transfer payload
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_position;
  } res_item_t;

  // table read address source
  typedef enum logic [1:0] {
    RA_LO    = 2'd0,
    RA_HI    = 2'd1,
    RA_MID   = 2'd2,
    RA_SHIFT = 2'd3
  } rd_sel_t;

  // reported position source
  typedef enum logic [1:0] {
    PS_NONE = 2'd0,
    PS_LO   = 2'd1,
    PS_MID  = 2'd2
  } pos_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     ram_rd;
    rd_sel_t  rd_sel;
    logic     shift_wr;
    logic     insert_wr;
    logic     latch_lo;
    logic     range_load;
    logic     div_step;
    logic     mid_load;
    logic     lower_hi;
    logic     raise_lo;
    logic     res_load;
    status_t  res_status;
    pos_sel_t res_sel;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_search;
    logic full;
    logic bad_pos;
    logic empty;
    logic shift_start;
    logic shift_more;
    logic out_of_range;
    logic ends_equal;
    logic key_lt;
    logic key_gt;
    logic range_ok;
    logic div_last;
    logic res_free;
  } dp_sts_t;

endpackage

[rtl/core/otis_ram.sv]
// ----------------------------------------------------------------------------
// otis_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module otis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/otis_datapath.sv]
// ----------------------------------------------------------------------------
// otis_datapath
// Table storage, fill count, search bounds, interpolation multiplier,
// bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module otis_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  otis_pkg::dp_cmd_t   ctl,
  output otis_pkg::dp_sts_t   sts,
  input  otis_pkg::cmd_item_t item_in,
  input  logic                res_stall,
  output logic                res_valid,
  output otis_pkg::res_item_t res
);

  localparam int AW     = $clog2(DEPTH);
  localparam int PW_POS = $clog2(DEPTH + 2);
  localparam int QW     = AW;
  localparam int PW     = otis_pkg::VAL_W + QW;
  localparam int DCW    = $clog2(QW + 1);
  localparam int CMPW   = ((PW_POS > otis_pkg::POS_W) ? PW_POS : otis_pkg::POS_W) + 1;
  localparam int VW     = otis_pkg::VAL_W;

  // captured command
  otis_pkg::op_t               op;
  logic [otis_pkg::POS_W-1:0]  pos;
  logic signed [VW-1:0]        key;

  // table bookkeeping and search bounds
  logic [PW_POS-1:0] count;
  logic [PW_POS-1:0] sh;
  logic [PW_POS-1:0] lo;
  logic [PW_POS-1:0] hi;
  logic [PW_POS-1:0] mid;

  // interpolation and division
  logic signed [VW-1:0] a;
  logic [VW-1:0]        ka;
  logic [PW-1:0]        rem;
  logic [PW-1:0]        dsh;
  logic [QW-1:0]        q;
  logic [DCW-1:0]       div_cnt;

  // ram signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  // combinational helpers
  logic signed [VW-1:0] rd_s;
  logic [CMPW-1:0]      cnt_w;
  logic [CMPW-1:0]      pos_eff;
  logic [CMPW-1:0]      ins_m1;
  logic [PW_POS-1:0]    span;
  logic [QW-1:0]        span_q;
  logic [PW-1:0]        prod;
  logic [VW:0]          ka_full;
  logic [VW:0]          den_full;
  logic                 ge;
  logic [PW_POS-1:0]    mid_sum;
  logic [PW_POS-1:0]    rd_pos;
  logic [PW_POS-1:0]    rd_pos_m1;
  logic [CMPW-1:0]      fp_w;

  otis_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_s = $signed(rd_data);

  // insert position checks, append resolves to count plus one
  assign cnt_w   = CMPW'(count);
  assign pos_eff = (pos == '0) ? (cnt_w + CMPW'(1)) : CMPW'(pos);
  assign ins_m1  = pos_eff - CMPW'(1);

  // interpolation numerator and bound differences
  assign span     = hi - lo;
  assign span_q   = span[QW-1:0];
  assign prod     = PW'(span_q) * PW'(ka);
  assign ka_full  = {key[VW-1], key} - {rd_s[VW-1], rd_s};
  assign den_full = {rd_s[VW-1], rd_s} - {a[VW-1], a};

  // restoring division step
  assign ge = (dsh <= rem);

  assign mid_sum = lo + PW_POS'(q);

  // read address select
  always_comb begin
    case (ctl.rd_sel)
      otis_pkg::RA_LO:    rd_pos = lo;
      otis_pkg::RA_HI:    rd_pos = hi;
      otis_pkg::RA_MID:   rd_pos = mid_sum;
      otis_pkg::RA_SHIFT: rd_pos = sh;
      default:            rd_pos = lo;
    endcase
  end

  assign rd_pos_m1 = rd_pos - PW_POS'(1);
  assign rd_addr   = rd_pos_m1[AW-1:0];

  // write port: shift moves an entry up, insert drops the new value in
  assign wr_en   = ctl.shift_wr | ctl.insert_wr;
  assign wr_addr = ctl.shift_wr ? sh[AW-1:0] : ins_m1[AW-1:0];
  assign wr_data = ctl.shift_wr ? rd_data : key;

  // status back to the controller
  always_comb begin
    sts              = '0;
    sts.is_search    = (op == otis_pkg::OP_SEARCH);
    sts.full         = (count == PW_POS'(DEPTH));
    sts.bad_pos      = (pos_eff > (cnt_w + CMPW'(1)));
    sts.empty        = (count == '0);
    sts.shift_start  = (CMPW'(sh) >= pos_eff);
    sts.shift_more   = (CMPW'(sh) > pos_eff);
    sts.out_of_range = (key < a) || (key > rd_s);
    sts.ends_equal   = (a == rd_s);
    sts.key_lt       = (key < rd_s);
    sts.key_gt       = (key > rd_s);
    sts.range_ok     = (lo <= hi) && (hi != '0);
    sts.div_last     = (div_cnt == '0);
    sts.res_free     = !res_valid || !res_stall;
  end

  // reported position
  always_comb begin
    case (ctl.res_sel)
      otis_pkg::PS_LO:  fp_w = CMPW'(lo);
      otis_pkg::PS_MID: fp_w = CMPW'(mid);
      default:          fp_w = '0;
    endcase
  end

  // control state: fill count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ctl.insert_wr) begin
        count <= count + PW_POS'(1);
      end
      if (ctl.res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op  <= item_in.operation;
      pos <= item_in.position;
      key <= item_in.value;
      sh  <= count;
      lo  <= PW_POS'(1);
      hi  <= count;
    end
    if (ctl.shift_wr) begin
      sh <= sh - PW_POS'(1);
    end
    if (ctl.latch_lo) begin
      a  <= rd_s;
      ka <= ka_full[VW-1:0];
    end
    if (ctl.range_load) begin
      rem     <= prod;
      dsh     <= PW'(den_full[VW-1:0]) << (QW - 1);
      q       <= '0;
      div_cnt <= DCW'(QW - 1);
    end
    if (ctl.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q       <= QW'({q, ge});
      dsh     <= dsh >> 1;
      div_cnt <= div_cnt - DCW'(1);
    end
    if (ctl.mid_load) begin
      mid <= mid_sum;
    end
    if (ctl.lower_hi) begin
      hi <= mid - PW_POS'(1);
    end
    if (ctl.raise_lo) begin
      lo <= mid + PW_POS'(1);
    end
    if (ctl.res_load) begin
      res.status         <= ctl.res_status;
      res.found_position <= fp_w[otis_pkg::POS_W-1:0];
    end
  end

  // interpolated probe never leaves the current bounds
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.mid_load |-> (mid_sum >= lo) && (mid_sum <= hi))
    else $error("probe position outside search bounds");

  // fill count only ever steps up by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> (count == $past(count) + PW_POS'(1)))
    else $error("fill count changed by other than one");

endmodule

[rtl/core/otis_ctrl.sv]
// ----------------------------------------------------------------------------
// otis_ctrl
// Sequencer for insert (shift then write) and search (bound reads,
// interpolation, division, probe) operations.
// ----------------------------------------------------------------------------
module otis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output otis_pkg::dp_cmd_t ctl,
  input  otis_pkg::dp_sts_t sts
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_SH_RD  = 13'b0000000000100,
    S_SH_WR  = 13'b0000000001000,
    S_INS_WR = 13'b0000000010000,
    S_RD_LO  = 13'b0000000100000,
    S_RD_HI  = 13'b0000001000000,
    S_RANGE  = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_MID    = 13'b0001000000000,
    S_PROBE  = 13'b0010000000000,
    S_LOOP   = 13'b0100000000000,
    S_RESP   = 13'b1000000000000
  } state_t;

  state_t               state;
  state_t               state_next;
  otis_pkg::status_t    fin_status;
  otis_pkg::status_t    fin_status_next;
  otis_pkg::pos_sel_t   fin_sel;
  otis_pkg::pos_sel_t   fin_sel_next;

  assign cmd_stall = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    fin_sel_next    = fin_sel;
    ctl             = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_search) begin
          if (sts.empty) begin
            fin_status_next = otis_pkg::ST_NOT_FOUND;
            fin_sel_next    = otis_pkg::PS_NONE;
            state_next      = S_RESP;
          end else begin
            state_next = S_RD_LO;
          end
        end else if (sts.full) begin
          fin_status_next = otis_pkg::ST_FULL;
          fin_sel_next    = otis_pkg::PS_NONE;
          state_next      = S_RESP;
        end else if (sts.bad_pos) begin
          fin_status_next = otis_pkg::ST_BAD_POS;
          fin_sel_next    = otis_pkg::PS_NONE;
          state_next      = S_RESP;
        end else if (sts.shift_start) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_SH_RD: begin
        ctl.ram_rd = 1'b1;
        ctl.rd_sel = otis_pkg::RA_SHIFT;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        ctl.shift_wr = 1'b1;
        state_next   = sts.shift_more ? S_SH_RD : S_INS_WR;
      end
      S_INS_WR: begin
        ctl.insert_wr   = 1'b1;
        fin_status_next = otis_pkg::ST_DONE;
        fin_sel_next    = otis_pkg::PS_NONE;
        state_next      = S_RESP;
      end
      S_RD_LO: begin
        ctl.ram_rd = 1'b1;
        ctl.rd_sel = otis_pkg::RA_LO;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        ctl.ram_rd   = 1'b1;
        ctl.rd_sel   = otis_pkg::RA_HI;
        ctl.latch_lo = 1'b1;
        state_next   = S_RANGE;
      end
      S_RANGE: begin
        if (sts.out_of_range) begin
          fin_status_next = otis_pkg::ST_NOT_FOUND;
          fin_sel_next    = otis_pkg::PS_NONE;
          state_next      = S_RESP;
        end else if (sts.ends_equal) begin
          fin_status_next = otis_pkg::ST_DONE;
          fin_sel_next    = otis_pkg::PS_LO;
          state_next      = S_RESP;
        end else begin
          ctl.range_load = 1'b1;
          state_next     = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        ctl.ram_rd   = 1'b1;
        ctl.rd_sel   = otis_pkg::RA_MID;
        ctl.mid_load = 1'b1;
        state_next   = S_PROBE;
      end
      S_PROBE: begin
        if (sts.key_lt) begin
          ctl.lower_hi = 1'b1;
          state_next   = S_LOOP;
        end else if (sts.key_gt) begin
          ctl.raise_lo = 1'b1;
          state_next   = S_LOOP;
        end else begin
          fin_status_next = otis_pkg::ST_DONE;
          fin_sel_next    = otis_pkg::PS_MID;
          state_next      = S_RESP;
        end
      end
      S_LOOP: begin
        if (sts.range_ok) begin
          state_next = S_RD_LO;
        end else begin
          fin_status_next = otis_pkg::ST_NOT_FOUND;
          fin_sel_next    = otis_pkg::PS_NONE;
          state_next      = S_RESP;
        end
      end
      S_RESP: begin
        ctl.res_status = fin_status;
        ctl.res_sel    = fin_sel;
        if (sts.res_free) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pending result code
  always_ff @(posedge clk) begin
    fin_status <= fin_status_next;
    fin_sel    <= fin_sel_next;
  end

  // an insert only commits on a legal position with room left
  a_insert_legal: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |-> (!sts.full && !sts.bad_pos))
    else $error("insert committed on full table or bad position");

  // every probe round starts from a non-empty range
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_LO) |-> sts.range_ok)
    else $error("search round started on empty range");

endmodule

[rtl/core/ordered_table_interpolation_search_unit.sv]
// ----------------------------------------------------------------------------
// ordered_table_interpolation_search_unit
// Ordered table of signed 32-bit values with positional insert and
// interpolation search, one operation at a time.
// ----------------------------------------------------------------------------
// The unit takes one command at a time and returns one result per command.
// An insert that moves m entries does one read and one write of the table
// RAM for each moved entry before writing the new value. A search runs
// probe rounds of two bound reads, the range check with the interpolation
// multiply, a bit-serial divider producing one quotient bit per cycle, the
// probe read, the compare and the loop test. A finished result sits in the
// output register, and the next command is taken while it waits there. The
// table needs no clearing after reset; only filled positions are ever read.
// ----------------------------------------------------------------------------
module ordered_table_interpolation_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  otis_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output otis_pkg::res_item_t res
);

  otis_pkg::dp_cmd_t ctl;
  otis_pkg::dp_sts_t sts;

  // sequencer
  otis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // table, arithmetic and output register
  otis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .item_in   (cmd),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered table interpolation search unit.
// A directed opening covers the empty table, rejected positions, front,
// middle and end inserts, duplicate entries and the value extremes. Random
// traffic then fills the table slowly with ascending inserts while searching
// it, breaks the ordering with a last insert and keeps searching a full table.
// Every command is predicted when it is accepted and each result is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1930;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [otis_pkg::VAL_W-1:0] word_t;

  // shadow of the table and the outcomes still owed by the unit
  class table_scoreboard;
    word_t               tbl [DEPTH];
    int                  fill;
    otis_pkg::res_item_t outcome_q [$];
    int unsigned         mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // expected outcome of one command, updating the shadow table
    function otis_pkg::res_item_t lookup_outcome(otis_pkg::cmd_item_t c);
      otis_pkg::res_item_t r;
      int        p;
      int        lo;
      int        hi;
      int        mid;
      bit        stop;
      longint    a;
      longint    b;
      longint    k;
      longint    probe;
      r.status         = otis_pkg::ST_DONE;
      r.found_position = '0;
      if (c.operation == otis_pkg::OP_INSERT) begin
        p = c.position;
        if (fill >= DEPTH) begin
          r.status = otis_pkg::ST_FULL;
        end else begin
          if (p == 0) p = fill + 1;
          if (p > fill + 1) begin
            r.status = otis_pkg::ST_BAD_POS;
          end else begin
            for (int i = fill; i >= p; i--) tbl[i] = tbl[i-1];
            tbl[p-1] = c.value;
            fill++;
          end
        end
      end else begin
        r.status = otis_pkg::ST_NOT_FOUND;
        lo   = 1;
        hi   = fill;
        stop = 1'b0;
        k    = c.value;
        while (!stop && lo <= hi && hi >= 1 && hi <= DEPTH) begin
          a = tbl[lo-1];
          b = tbl[hi-1];
          if (k < a || k > b) begin
            // key outside the end values
            stop = 1'b1;
          end else if (a == b) begin
            // equal end values: direct compare, low end reported
            r.status         = otis_pkg::ST_DONE;
            r.found_position = lo[otis_pkg::POS_W-1:0];
            stop             = 1'b1;
          end else begin
            probe = longint'(hi - lo) * (k - a) / (b - a);
            mid   = lo + int'(probe);
            if (k < longint'(tbl[mid-1])) begin
              hi = mid - 1;
            end else if (k > longint'(tbl[mid-1])) begin
              lo = mid + 1;
            end else begin
              r.status         = otis_pkg::ST_DONE;
              r.found_position = mid[otis_pkg::POS_W-1:0];
              stop             = 1'b1;
            end
          end
        end
      end
      return r;
    endfunction

    // accepted command: predict and queue its outcome
    function void note_command(otis_pkg::cmd_item_t c);
      outcome_q.push_back(lookup_outcome(c));
    endfunction

    // accepted result: compare with the oldest outcome
    function void check_outcome(otis_pkg::res_item_t r);
      otis_pkg::res_item_t e;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d pos %0d", r.status, r.found_position);
      end else begin
        e = outcome_q.pop_front();
        if (r.status !== e.status || r.found_position !== e.found_position) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d pos %0d, got status %0d pos %0d",
                     e.status, e.found_position, r.status, r.found_position);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  otis_pkg::cmd_item_t cmd;
  logic                res_valid;
  logic                res_stall;
  otis_pkg::res_item_t res;
  bit                  calm;

  table_scoreboard sb;

  ordered_table_interpolation_search_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gap or stall, switched off during the calm stretch
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 21);
  endfunction

  function automatic otis_pkg::cmd_item_t mk(otis_pkg::op_t o, int p, word_t v);
    otis_pkg::cmd_item_t c;
    c.operation = o;
    c.position  = p[otis_pkg::POS_W-1:0];
    c.value     = v;
    return c;
  endfunction

  // values biased to extremes and a narrow band that makes duplicates
  function automatic word_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return $urandom_range(0, 80) - 40;
      default: return $urandom;
    endcase
  endfunction

  // mostly keys present in the table or just beside them
  function automatic word_t pick_key();
    int sel;
    word_t v;
    sel = $urandom_range(0, 9);
    if (sb.fill == 0 || sel > 6) return pick_value();
    v = sb.tbl[$urandom_range(0, sb.fill - 1)];
    if (sel == 5) v = v + 1;
    if (sel == 6) v = v - 1;
    return v;
  endfunction

  // position that keeps the table ascending, first or last among equals
  function automatic int ordered_slot(word_t v);
    int first;
    int last;
    first = 0;
    last  = 0;
    for (int p = 1; p <= sb.fill + 1; p++) begin
      if ((p == 1 || sb.tbl[p-2] <= v) && (p == sb.fill + 1 || v <= sb.tbl[p-1])) begin
        if (first == 0) first = p;
        last = p;
      end
    end
    if ($urandom_range(0, 1)) last = first;
    if (last == sb.fill + 1 && $urandom_range(0, 1)) last = 0;
    return last;
  endfunction

  // one command transfer, entered and left at a falling edge
  task automatic send(otis_pkg::cmd_item_t c);
    while (take_gap()) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd       = c;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // hold the sender until every outcome has come back
  task automatic drain();
    cmd_valid = 1'b0;
    while (sb.outcome_q.size() != 0) @(negedge clk);
  endtask

  // result side stalls
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      res_stall = take_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (res_valid === 1'b1 && res_stall === 1'b0) sb.check_outcome(res);
  end

  // stimulus
  initial begin
    otis_pkg::cmd_item_t c;
    word_t               v;
    sb        = new();
    cmd_valid = 1'b0;
    cmd       = '0;
    calm      = 1'b0;
    rst       = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opening
    send(mk(otis_pkg::OP_SEARCH, 0, 0));               // empty table
    send(mk(otis_pkg::OP_INSERT, 3, 7));               // position too far
    send(mk(otis_pkg::OP_INSERT, 16, 7));
    send(mk(otis_pkg::OP_INSERT, 0, 100));             // append
    send(mk(otis_pkg::OP_SEARCH, 16, 100));
    send(mk(otis_pkg::OP_SEARCH, 0, 99));              // below low end
    send(mk(otis_pkg::OP_INSERT, 1, 100));             // duplicate at the front
    send(mk(otis_pkg::OP_SEARCH, 1, 100));             // equal end values
    send(mk(otis_pkg::OP_SEARCH, 2, 101));             // above high end
    send(mk(otis_pkg::OP_INSERT, 1, 32'sh8000_0000));
    send(mk(otis_pkg::OP_INSERT, 0, 32'sh7fff_ffff));
    send(mk(otis_pkg::OP_SEARCH, 0, 32'sh8000_0000));
    send(mk(otis_pkg::OP_SEARCH, 15, 32'sh7fff_ffff));
    send(mk(otis_pkg::OP_SEARCH, 0, 100));
    send(mk(otis_pkg::OP_SEARCH, 0, 0));               // miss inside the range
    send(mk(otis_pkg::OP_INSERT, 2, -5));              // insert in the middle
    send(mk(otis_pkg::OP_SEARCH, 0, -5));
    send(mk(otis_pkg::OP_SEARCH, 0, 200));
    send(mk(otis_pkg::OP_SEARCH, 0, 32'sh8000_0001));
    drain();

    // random traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      if (n == 400) drain();
      if (sb.fill == DEPTH - 1 && n >= 1400) begin
        // last free slot: break the ordering for good
        c = mk(otis_pkg::OP_INSERT, $urandom_range(1, 8), 32'sh7fff_ffff);
      end else if (sb.fill < DEPTH - 1 && (n >= 1300 || $urandom_range(0, 39) == 0)) begin
        if ($urandom_range(0, 4) == 0 && sb.fill + 2 <= DEPTH) begin
          c = mk(otis_pkg::OP_INSERT, $urandom_range(sb.fill + 2, DEPTH), pick_value());
        end else begin
          v = pick_value();
          c = mk(otis_pkg::OP_INSERT, ordered_slot(v), v);
        end
      end else if (sb.fill == DEPTH && $urandom_range(0, 39) == 0) begin
        c = mk(otis_pkg::OP_INSERT, $urandom_range(0, DEPTH), pick_value());
      end else begin
        c = mk(otis_pkg::OP_SEARCH, $urandom_range(0, DEPTH), pick_key());
      end
      send(c);
    end
    calm = 1'b0;

    // wind down
    drain();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #25000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/otis_pkg.sv
rtl/core/otis_ram.sv
rtl/core/otis_datapath.sv
rtl/core/otis_ctrl.sv
rtl/core/ordered_table_interpolation_search_unit.sv
tb/tb_top.sv
